@@ sv/radix2_fft_inplace_macros.svh @@
// Assertion macros for the radix-2 FFT block
`ifndef RADIX2_FFT_INPLACE_MACROS_SVH
`define RADIX2_FFT_INPLACE_MACROS_SVH
// Assert that an antecedent implies a consequent in the next cycle
`define FFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
// Assert that a condition never holds
`define FFT_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");
`endif

@@ sv/fft_pkg.sv @@
// Shared types, constants and twiddle table for the radix-2 FFT
`timescale 1ns / 1ps
package fft_pkg;
    localparam int MAX_POINTS   = 64;
    localparam int SAMPLE_BITS  = 16;
    localparam int TWIDDLE_BITS = 16;
    localparam int DATA_BITS    = 23;
    localparam int ADDR_BITS    = 6;
    localparam int DEPTH        = 64;
    localparam int TW_FRAC      = TWIDDLE_BITS - 1;

    typedef logic signed [DATA_BITS-1:0] data_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                 load;       // write sample at addr_a
        logic                 pad;        // write zero at addr_a
        logic                 wr_swap;    // write rd data crossed (bit reversal)
        logic                 wr_bfly;    // write butterfly result
        logic                 emit;       // capture read data as a result
        logic [ADDR_BITS-1:0] addr_a;
        logic [ADDR_BITS-1:0] addr_b;
        logic [4:0]           tw_m;
        logic [ADDR_BITS-1:0] out_idx;
        logic                 out_last;
    } fft_cmd_t;

    typedef struct packed {
        logic out_full;
    } fft_sts_t;

    // sin(2*pi*j/64) in Q1.23
    function automatic logic [23:0] qsin_q23(input logic [4:0] j);
        logic [23:0] r;
        begin
            unique case (j)
                5'd0: r = 24'd0;        5'd1: r = 24'd822227;
                5'd2: r = 24'd1636536;  5'd3: r = 24'd2435084;
                5'd4: r = 24'd3210181;  5'd5: r = 24'd3954362;
                5'd6: r = 24'd4660461;  5'd7: r = 24'd5321677;
                5'd8: r = 24'd5931642;  5'd9: r = 24'd6484482;
                5'd10: r = 24'd6974873; 5'd11: r = 24'd7398092;
                5'd12: r = 24'd7750063; 5'd13: r = 24'd8027397;
                5'd14: r = 24'd8227423; 5'd15: r = 24'd8348215;
                default: r = 24'd8388608;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [TWIDDLE_BITS:0] qentry(input logic [4:0] j);
        logic [24:0] t;
        begin
            t = {1'b0, qsin_q23(j)} + 25'(1 << (24 - TWIDDLE_BITS - 1));
            return $signed({1'b0, t[24 - TWIDDLE_BITS +: TWIDDLE_BITS]});
        end
    endfunction

    function automatic logic [ADDR_BITS-1:0] bitrev(input logic [ADDR_BITS-1:0] i,
                                                   input logic [2:0] lg);
        logic [ADDR_BITS-1:0] f;
        begin
            for (int b = 0; b < ADDR_BITS; b++) f[b] = i[ADDR_BITS-1-b];
            return f >> (3'(ADDR_BITS) - lg);
        end
    endfunction
endpackage

@@ sv/radix2_fft_inplace.sv @@
// Top level of the in-place radix-2 FFT: controller plus datapath
// Usage: stream real samples on s_axis (tdata = sample, tlast = last_sample).
// A frame closes on tlast or on the 64th sample and is zero-padded to a power
// of two. Samples are taken one per cycle while loading; tready drops while a
// frame is transformed and emitted.
// Processing of an n-point frame: zero padding up to n points, a sweep over every
// index for bit reversal with a swap for each reversed pair, then (n/2)*log2 n
// butterflies run one at a time (set by the single shared butterfly unit and
// the two store write slots), then bins are issued one at a time through the
// output register.
// Results on m_axis: tdata = bin_real, bin_imag, bin_index from bit 0 up;
// tlast carries last_bin on the final bin. A stalled receiver holds the output
// register and pauses bin issue; nothing is dropped.
// Reset clears the controller to the load state with an empty frame; the
// point store holds no reset value and is always written before it is read.
`timescale 1ns / 1ps
`include "radix2_fft_inplace_macros.svh"
module radix2_fft_inplace (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] s_axis_tdata,   // sample
    input  logic        s_axis_tlast,   // last_sample
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    output logic [55:0] m_axis_tdata,   // bin_real, bin_imag, bin_index
    output logic        m_axis_tlast,   // last_bin
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);
    fft_pkg::fft_cmd_t cmd;
    fft_pkg::fft_sts_t sts;

    fft_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_tlast(s_axis_tlast),
        .cmd(cmd), .sts(sts)
    );

    fft_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .sample(s_axis_tdata[fft_pkg::SAMPLE_BITS-1:0]),
        .m_tdata(m_axis_tdata), .m_tvalid(m_axis_tvalid),
        .m_tlast(m_axis_tlast), .m_tready(m_axis_tready)
    );

    `FFT_ASSERT_NEVER(a_no_emit_when_full, cmd.emit && sts.out_full)
    `FFT_ASSERT_NEXT(a_emit_valid, cmd.emit, ##1 m_axis_tvalid)
    `FFT_ASSERT_NEVER(a_no_load_outside, cmd.load && !s_axis_tready)
endmodule

@@ sv/fft_ram.sv @@
// Generic single-write, dual-read RAM with registered read
`timescale 1ns / 1ps
module fft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

@@ sv/fft_dp.sv @@
// FFT datapath: point store, butterfly unit and output register
`timescale 1ns / 1ps
module fft_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fft_pkg::fft_cmd_t      cmd,
    output fft_pkg::fft_sts_t      sts,
    input  logic [fft_pkg::SAMPLE_BITS-1:0] sample,
    output logic [55:0]            m_tdata,
    output logic                   m_tvalid,
    output logic                   m_tlast,
    input  logic                   m_tready
);
    localparam int W  = fft_pkg::DATA_BITS;
    localparam int TB = fft_pkg::TWIDDLE_BITS;
    localparam int PW = W + TB + 2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_SWAP = 2'd1;
    localparam logic [1:0] KIND_BFLY = 2'd2;
    localparam logic [1:0] KIND_EMIT = 2'd3;

    // Store has a single write port, shared by load, pad, swap and both butterfly write slots
    logic [2*W-1:0] rd_a, rd_b;
    logic [2*W-1:0] wdat;
    logic [fft_pkg::ADDR_BITS-1:0] waddr;
    logic we;

    fft_ram #(.WIDTH(2*W), .DEPTH(fft_pkg::DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdat),
        .raddr_a(cmd.addr_a), .raddr_b(cmd.addr_b),
        .rdata_a(rd_a), .rdata_b(rd_b)
    );

    // Pipeline: stage 1 read, stage 2 multiply, stage 3 round/add, write a, then b
    logic [1:0] s1_kind_reg;
    logic [fft_pkg::ADDR_BITS-1:0] s1_a_reg, s1_b_reg, s1_idx_reg;
    logic s1_last_reg;
    logic signed [TB:0] s1_c_reg, s1_s_reg;
    logic signed [TB:0] c_next, s_next;
    logic [4:0] m;

    always_comb
    begin
        m = cmd.tw_m;
        if (m <= 5'd16)
        begin
            s_next = fft_pkg::qentry(m);
            c_next = fft_pkg::qentry(5'd16 - m);
        end
        else
        begin
            s_next = fft_pkg::qentry(5'd0 - m);
            c_next = -fft_pkg::qentry(m - 5'd16);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_kind_reg <= KIND_NONE;
        else if (cmd.wr_swap)
            s1_kind_reg <= KIND_SWAP;
        else if (cmd.wr_bfly)
            s1_kind_reg <= KIND_BFLY;
        else if (cmd.emit)
            s1_kind_reg <= KIND_EMIT;
        else
            s1_kind_reg <= KIND_NONE;
    end

    always_ff @(posedge clk)
    begin
        s1_a_reg <= cmd.addr_a;
        s1_b_reg <= cmd.addr_b;
        s1_idx_reg <= cmd.out_idx;
        s1_last_reg <= cmd.out_last;
        s1_c_reg <= c_next;
        s1_s_reg <= s_next;
    end

    // Stage 2: products
    logic s2_bfly_reg;
    logic [fft_pkg::ADDR_BITS-1:0] s2_a_reg, s2_b_reg;
    logic signed [PW-1:0] p_rc_reg, p_is_reg, p_ic_reg, p_rs_reg;
    logic [2*W-1:0] s2_u_reg;
    logic signed [W-1:0] br, bi;
    assign br = rd_b[W-1:0];
    assign bi = rd_b[2*W-1:W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_bfly_reg <= 1'b0;
        else
            s2_bfly_reg <= (s1_kind_reg == KIND_BFLY);
    end

    always_ff @(posedge clk)
    begin
        s2_a_reg <= s1_a_reg;
        s2_b_reg <= s1_b_reg;
        s2_u_reg <= rd_a;
        p_rc_reg <= PW'(br) * PW'(s1_c_reg);
        p_is_reg <= PW'(bi) * PW'(s1_s_reg);
        p_ic_reg <= PW'(bi) * PW'(s1_c_reg);
        p_rs_reg <= PW'(br) * PW'(s1_s_reg);
    end

    // Stage 3: round and add/subtract
    logic signed [PW-1:0] sr, si, vr, vi;
    logic signed [W+1:0] ar, ai, xr, xi;
    logic signed [W-1:0] ur, ui;
    assign ur = s2_u_reg[W-1:0];
    assign ui = s2_u_reg[2*W-1:W];

    function automatic logic signed [W-1:0] sat(input logic signed [W+1:0] v);
        begin
            if (v > (W+2)'((1 << (W-1)) - 1))
                return W'((1 << (W-1)) - 1);
            else if (v < -(W+2)'(1 << (W-1)))
                return W'(1 << (W-1));
            else
                return v[W-1:0];
        end
    endfunction

    always_comb
    begin
        sr = p_rc_reg + p_is_reg + PW'(1 << (fft_pkg::TW_FRAC - 1));
        si = p_ic_reg - p_rs_reg + PW'(1 << (fft_pkg::TW_FRAC - 1));
        vr = sr >>> fft_pkg::TW_FRAC;
        vi = si >>> fft_pkg::TW_FRAC;
        ar = (W+2)'(ur) + (W+2)'(vr);
        ai = (W+2)'(ui) + (W+2)'(vi);
        xr = (W+2)'(ur) - (W+2)'(vr);
        xi = (W+2)'(ui) - (W+2)'(vi);
    end

    logic s3_bwr_reg;
    logic [fft_pkg::ADDR_BITS-1:0] s3_b_reg;
    logic [2*W-1:0] s3_bd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_bwr_reg <= 1'b0;
        else
            s3_bwr_reg <= s2_bfly_reg || (s1_kind_reg == KIND_SWAP);
    end

    always_ff @(posedge clk)
    begin
        if (s1_kind_reg == KIND_SWAP)
        begin
            s3_b_reg <= s1_b_reg;
            s3_bd_reg <= rd_a;
        end
        else
        begin
            s3_b_reg <= s2_b_reg;
            s3_bd_reg <= {sat(xi), sat(xr)};
        end
    end

    // Write arbitration: controller spaces commands so slots never collide
    always_comb
    begin
        we = 1'b0;
        waddr = cmd.addr_a;
        wdat = '0;
        priority if (cmd.load || cmd.pad)
        begin
            we = 1'b1;
            wdat = cmd.load ? {W'(0), W'($signed(sample))} : '0;
        end
        else if (s1_kind_reg == KIND_SWAP)
        begin
            we = 1'b1;
            waddr = s1_a_reg;
            wdat = rd_b;
        end
        else if (s2_bfly_reg)
        begin
            we = 1'b1;
            waddr = s2_a_reg;
            wdat = {sat(ai), sat(ar)};
        end
        else if (s3_bwr_reg)
        begin
            we = 1'b1;
            waddr = s3_b_reg;
            wdat = s3_bd_reg;
        end
    end

    // Output register
    logic out_v_reg, out_last_reg;
    logic [55:0] out_d_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (s1_kind_reg == KIND_EMIT)
            out_v_reg <= 1'b1;
        else if (m_tready)
            out_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_kind_reg == KIND_EMIT)
        begin
            out_d_reg <= {4'd0, s1_idx_reg, rd_a[2*W-1:W], rd_a[W-1:0]};
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata = out_d_reg;
    assign m_tlast = out_last_reg;
    assign sts.out_full = out_v_reg && !m_tready;
endmodule

@@ sv/fft_ctrl.sv @@
// FFT controller: load, pad, bit reversal, butterfly stages and emission
`timescale 1ns / 1ps
module fft_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tlast,
    output fft_pkg::fft_cmd_t cmd,
    input  fft_pkg::fft_sts_t sts
);
    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_REV  = 3'd2;
    localparam logic [2:0] ST_BFLY = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;
    localparam logic [2:0] ST_WAIT = 3'd5;
    localparam int AB = fft_pkg::ADDR_BITS;
    localparam int CAP = (fft_pkg::MAX_POINTS > fft_pkg::DEPTH) ? fft_pkg::DEPTH
                                                                : fft_pkg::MAX_POINTS;

    logic [2:0] state_reg, state_next, after_reg, after_next;
    logic [AB:0] cnt_reg, cnt_next;       // loaded count, then sweep index
    logic [AB:0] n_reg, n_next;
    logic [2:0] lg_reg, lg_next;
    logic [2:0] stg_reg, stg_next;        // butterfly stage 0..lg-1
    logic [AB-1:0] bf_reg, bf_next;       // butterfly number in stage
    logic [2:0] wait_reg, wait_next;

    logic [AB:0] cnt_inc;
    logic [AB-1:0] half, ia, ib, k, rv, i6;
    logic [2:0] lgc;
    logic [AB:0] np;

    always_comb
    begin
        cnt_inc = cnt_reg + 1'b1;
        lgc = 3'd0;
        for (int b = 0; b <= AB; b++)
            if ((AB+1)'(1 << b) < cnt_inc && b < AB)
                lgc = 3'(b + 1);
        np = (AB+1)'(1) << lgc;
        half = AB'(1) << stg_reg;
        k = bf_reg & (half - 1'b1);
        ia = ((bf_reg >> stg_reg) << (stg_reg + 1'b1)) | k;
        ib = ia | half;
        i6 = cnt_reg[AB-1:0];
        rv = fft_pkg::bitrev(i6, lg_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        cnt_next = cnt_reg;
        n_next = n_reg;
        lg_next = lg_reg;
        stg_next = stg_reg;
        bf_next = bf_reg;
        wait_next = wait_reg;
        cmd = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                cmd.addr_a = cnt_reg[AB-1:0];
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    cnt_next = cnt_inc;
                    if (s_tlast || cnt_inc >= (AB+1)'(CAP))
                    begin
                        n_next = np;
                        lg_next = lgc;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (cnt_reg < n_reg)
                begin
                    cmd.pad = 1'b1;
                    cmd.addr_a = cnt_reg[AB-1:0];
                    cnt_next = cnt_inc;
                end
                else
                begin
                    cnt_next = '0;
                    state_next = (lg_reg == 3'd0) ? ST_EMIT : ST_REV;
                end
            end
            ST_REV:
            begin
                // swap takes two write slots; keep a gap so pipelines clear
                if (wait_reg != 3'd0)
                    wait_next = wait_reg - 1'b1;
                else if (cnt_reg < n_reg)
                begin
                    cnt_next = cnt_inc;
                    if (i6 < rv)
                    begin
                        cmd.wr_swap = 1'b1;
                        cmd.addr_a = i6;
                        cmd.addr_b = rv;
                        wait_next = 3'd2;
                    end
                end
                else
                begin
                    stg_next = '0;
                    bf_next = '0;
                    state_next = ST_BFLY;
                end
            end
            ST_BFLY:
            begin
                // each butterfly runs alone through read, multiply, write a, write b
                if (wait_reg != 3'd0)
                    wait_next = wait_reg - 1'b1;
                else
                begin
                    cmd.wr_bfly = 1'b1;
                    cmd.addr_a = ia;
                    cmd.addr_b = ib;
                    cmd.tw_m = 5'(k << (3'(AB - 1) - stg_reg));
                    wait_next = 3'd3;
                    if ({1'b0, bf_reg} == (n_reg >> 1) - 1'b1)
                    begin
                        bf_next = '0;
                        if (stg_reg == lg_reg - 1'b1)
                        begin
                            after_next = ST_EMIT;
                            state_next = ST_WAIT;
                            cnt_next = '0;
                        end
                        else
                            stg_next = stg_reg + 1'b1;
                    end
                    else
                        bf_next = bf_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (wait_reg != 3'd0)
                    wait_next = wait_reg - 1'b1;
                else
                    state_next = after_reg;
            end
            ST_EMIT:
            begin
                // hold while the output register is full and stalled; each bin is followed by a wait gap
                if (wait_reg != 3'd0)
                    wait_next = wait_reg - 1'b1;
                else if (!sts.out_full)
                begin
                    cmd.emit = 1'b1;
                    cmd.addr_a = cnt_reg[AB-1:0];
                    cmd.out_idx = cnt_reg[AB-1:0];
                    cmd.out_last = (cnt_inc == n_reg);
                    cnt_next = cnt_inc;
                    wait_next = 3'd2;
                    if (cnt_inc == n_reg)
                    begin
                        after_next = ST_LOAD;
                        state_next = ST_WAIT;
                        cnt_next = '0;
                    end
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            after_reg <= ST_LOAD;
            cnt_reg <= '0;
            n_reg <= '0;
            lg_reg <= '0;
            stg_reg <= '0;
            bf_reg <= '0;
            wait_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            cnt_reg <= cnt_next;
            n_reg <= n_next;
            lg_reg <= lg_next;
            stg_reg <= stg_next;
            bf_reg <= bf_next;
            wait_reg <= wait_next;
        end
    end
endmodule
